// ===== hdl/brr_block_decoder_top_macros.svh =====
// Assertion macros for the block decoder top level.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef BRR_BLOCK_DECODER_TOP_MACROS_SVH
`define BRR_BLOCK_DECODER_TOP_MACROS_SVH

// same-cycle implication
`define BRR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("brr_block_decoder: same-cycle check failed");

// next-cycle implication
`define BRR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("brr_block_decoder: next-cycle check failed");

`endif

// ===== hdl/brr_pkg.sv =====
// Shared types and constants of the block decoder.
// No dependencies.
package brr_pkg;

  localparam logic [3:0] BLOCK_LAST  = 4'd8;
  localparam logic [3:0] SHIFT_LIMIT = 4'd12;

  localparam logic [1:0] FLT_NONE = 2'd0;
  localparam logic [1:0] FLT_ONE  = 2'd1;
  localparam logic [1:0] FLT_TWO  = 2'd2;
  localparam logic [1:0] FLT_THREE = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HI,
    ST_LO
  } brr_state_t;

  typedef struct packed {
    logic load;
    logic header;
    logic dec_hi;
    logic dec_lo;
  } brr_cmd_t;

  typedef struct packed {
    logic pos_zero;
    logic out_free;
  } brr_sts_t;

endpackage

// ===== hdl/brr_block_decoder_top.sv =====
// BRR block decoder: a data beat is accepted, then decoded high nibble first,
// low nibble once the result register is free; a header beat is only accepted.
// The single predictor decodes the two nibbles of a byte one after the other.
// A finished result waits in the output register while the next beat is taken.
// Depends on brr_pkg, brr_ctrl, brr_dp, brr_pred and the macros header.
`include "brr_block_decoder_top_macros.svh"

module brr_block_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte[7:0]
  input  logic        in_tuser,   // restart
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // sample_first[15:0], sample_second[31:16]
  output logic [1:0]  out_tuser   // end_block[0], loop_block[1]
);
  import brr_pkg::*;

  brr_cmd_t cmd;
  brr_sts_t sts;

  brr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  brr_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .data_byte  (in_tdata),
    .restart    (in_tuser),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  `BRR_ASSERT_IMP(a_commit_free, cmd.dec_lo, sts.out_free)
  `BRR_ASSERT_NXT(a_header_no_dec, cmd.load && cmd.header, !cmd.dec_hi && in_tready)
  `BRR_ASSERT_NXT(a_hi_then_busy, cmd.dec_hi, !in_tready)
  `BRR_ASSERT_IMP(a_valid_source, $rose(out_tvalid), $past(cmd.dec_lo))

endmodule

// ===== hdl/brr_pred.sv =====
// Two-tap predictor: scales one nibble and adds the selected prediction.
// Depends on brr_pkg for the filter codes.
module brr_pred (
  input  logic [3:0]  nibble,
  input  logic [3:0]  shift,
  input  logic [1:0]  filter,
  input  logic [15:0] hist_p,
  input  logic [15:0] hist_q,
  output logic [15:0] sample
);
  import brr_pkg::*;

  logic signed [23:0] pw;
  logic signed [23:0] qw;
  logic signed [23:0] base;
  logic signed [23:0] p15;
  logic signed [23:0] p61;
  logic signed [23:0] p115;
  logic signed [23:0] q15;
  logic signed [23:0] q13;
  logic signed [23:0] pred;
  logic signed [23:0] sum;
  logic        [15:0] scaled;

  assign pw     = {{8{hist_p[15]}}, hist_p};
  assign qw     = {{8{hist_q[15]}}, hist_q};
  assign scaled = {{12{nibble[3]}}, nibble} << shift;
  assign base   = {{8{scaled[15]}}, scaled};

  assign p15  = ((pw <<< 4) - pw) >>> 4;
  assign p61  = ((pw <<< 6) - (pw <<< 1) - pw) >>> 5;
  assign p115 = ((pw <<< 7) - (pw <<< 3) - (pw <<< 2) - pw) >>> 6;
  assign q15  = ((qw <<< 4) - qw) >>> 4;
  assign q13  = ((qw <<< 4) - (qw <<< 1) - qw) >>> 4;

  always_comb begin
    unique case (filter)
      FLT_NONE:  pred = '0;
      FLT_ONE:   pred = p15;
      FLT_TWO:   pred = p61 - q15;
      FLT_THREE: pred = p115 - q13;
      default:   pred = '0;
    endcase
  end

  assign sum    = base + pred;
  assign sample = sum[15:0];

endmodule

// ===== hdl/brr_dp.sv =====
// Datapath: block position, header fields, history, output register.
// Depends on brr_pkg and brr_pred.
module brr_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  brr_pkg::brr_cmd_t cmd,
  output brr_pkg::brr_sts_t sts,
  input  logic [7:0]        data_byte,
  input  logic              restart,
  input  logic              out_tready,
  output logic              out_tvalid,
  output logic [31:0]       out_tdata,
  output logic [1:0]        out_tuser
);
  import brr_pkg::*;

  logic [3:0]  pos_r, pos_nxt;
  logic [3:0]  shift_r, shift_nxt;
  logic [1:0]  filter_r, filter_nxt;
  logic        end_r, end_nxt;
  logic        loop_r, loop_nxt;
  logic [15:0] hnew_r, hnew_nxt;
  logic [15:0] hold_r, hold_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic [15:0] first_r, first_nxt;
  logic [31:0] odata_r, odata_nxt;
  logic [1:0]  ouser_r, ouser_nxt;
  logic        ovalid_r, ovalid_nxt;
  logic [3:0]  nibble;
  logic [15:0] sample;

  assign nibble = cmd.dec_lo ? byte_r[3:0] : byte_r[7:4];

  brr_pred u_pred (
    .nibble (nibble),
    .shift  (shift_r),
    .filter (filter_r),
    .hist_p (hnew_r),
    .hist_q (hold_r),
    .sample (sample)
  );

  always_comb begin
    pos_nxt    = pos_r;
    shift_nxt  = shift_r;
    filter_nxt = filter_r;
    end_nxt    = end_r;
    loop_nxt   = loop_r;
    hnew_nxt   = hnew_r;
    hold_nxt   = hold_r;
    byte_nxt   = byte_r;
    first_nxt  = first_r;
    odata_nxt  = odata_r;
    ouser_nxt  = ouser_r;
    ovalid_nxt = ovalid_r && !out_tready;
    if (cmd.load) begin
      byte_nxt = data_byte;
      if (restart) begin
        hnew_nxt = '0;
        hold_nxt = '0;
      end
      if (cmd.header) begin
        shift_nxt  = (data_byte[7:4] > SHIFT_LIMIT) ? SHIFT_LIMIT : data_byte[7:4];
        filter_nxt = data_byte[3:2];
        loop_nxt   = data_byte[1];
        end_nxt    = data_byte[0];
        pos_nxt    = 4'd1;
      end
    end
    if (cmd.dec_hi) begin
      first_nxt = sample;
      hold_nxt  = hnew_r;
      hnew_nxt  = sample;
    end
    if (cmd.dec_lo) begin
      hold_nxt   = hnew_r;
      hnew_nxt   = sample;
      odata_nxt  = {sample, first_r};
      ouser_nxt  = {loop_r, end_r};
      ovalid_nxt = 1'b1;
      pos_nxt    = (pos_r == BLOCK_LAST) ? 4'd0 : pos_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      hnew_r   <= '0;
      hold_r   <= '0;
      ovalid_r <= 1'b0;
      shift_r  <= '0;
      filter_r <= '0;
      end_r    <= 1'b0;
      loop_r   <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      hnew_r   <= hnew_nxt;
      hold_r   <= hold_nxt;
      ovalid_r <= ovalid_nxt;
      shift_r  <= shift_nxt;
      filter_r <= filter_nxt;
      end_r    <= end_nxt;
      loop_r   <= loop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r  <= byte_nxt;
    first_r <= first_nxt;
    odata_r <= odata_nxt;
    ouser_r <= ouser_nxt;
  end

  assign sts.pos_zero = (pos_r == 4'd0);
  assign sts.out_free = !ovalid_r || out_tready;
  assign out_tvalid   = ovalid_r;
  assign out_tdata    = odata_r;
  assign out_tuser    = ouser_r;

endmodule

// ===== hdl/brr_ctrl.sv =====
// Controller: input handshake and sequencing of the two nibble decodes.
// Depends on brr_pkg.
module brr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tuser,
  output logic              in_tready,
  input  brr_pkg::brr_sts_t sts,
  output brr_pkg::brr_cmd_t cmd
);
  import brr_pkg::*;

  brr_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    cmd        = '0;
    cmd.header = in_tuser || sts.pos_zero;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
        if (in_tvalid && !cmd.header) begin
          state_nxt = ST_HI;
        end
      end
      ST_HI: begin
        cmd.dec_hi = 1'b1;
        state_nxt  = ST_LO;
      end
      ST_LO: begin
        if (sts.out_free) begin
          cmd.dec_lo = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== test/tb_top.sv =====
// Self-checking bench for brr_block_decoder_top: a queued stream driver, a
// result monitor and a predictor of the BRR nibble decode kept in step per beat.
// Depends on brr_pkg and the brr_block_decoder_top RTL.
module tb_top;
  import brr_pkg::*;

  localparam int ITEM_TOTAL    = 550;
  localparam int RST_CYCLES    = 7;
  localparam int IDLE_LIMIT    = 4000;
  localparam int HOLD_AT       = 120;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 16;

  typedef struct {
    logic [7:0] data_val;
    logic       restart;
    bit         drain_first;
  } stream_beat_t;

  typedef struct packed {
    logic [15:0] first;
    logic [15:0] second;
    logic        end_flag;
    logic        loop_flag;
  } decoded_pair_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_LIGHT,
    RX_HEAVY
  } rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;

  stream_beat_t  beat_queue[$];
  decoded_pair_t expected_pairs[$];

  logic [3:0]  blk_pos = '0;
  logic [3:0]  hdr_shift = '0;
  logic [1:0]  hdr_filter = FLT_NONE;
  logic        hdr_end = 1'b0;
  logic        hdr_loop = 1'b0;
  logic [15:0] hist_new = '0;
  logic [15:0] hist_old = '0;

  int mismatches = 0;
  int pairs_seen = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int mode_left = 0;
  rx_mode_t rx_mode = RX_OPEN;

  brr_block_decoder_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #4 clk = ~clk;

  function automatic logic [15:0] next_sample(input logic [3:0] nib);
    int s;
    int p;
    int q;
    int acc;
    s = $signed(nib);
    p = $signed(hist_new);
    q = $signed(hist_old);
    acc = s <<< hdr_shift;
    case (hdr_filter)
      FLT_NONE: ;
      FLT_ONE: acc += (p * 15) >>> 4;
      FLT_TWO: acc += ((p * 61) >>> 5) - ((q * 15) >>> 4);
      FLT_THREE: acc += ((p * 115) >>> 6) - ((q * 13) >>> 4);
      default: ;
    endcase
    hist_old = hist_new;
    hist_new = acc[15:0];
    return acc[15:0];
  endfunction

  function automatic void decode_beat(input logic [7:0] data, input logic restart);
    decoded_pair_t pair;
    if (restart) begin
      blk_pos = '0;
      hist_new = '0;
      hist_old = '0;
    end
    if (blk_pos == '0) begin
      hdr_shift = (data[7:4] > SHIFT_LIMIT) ? SHIFT_LIMIT : data[7:4];
      hdr_filter = data[3:2];
      hdr_loop = data[1];
      hdr_end = data[0];
      blk_pos = 4'd1;
    end else begin
      pair.first = next_sample(data[7:4]);
      pair.second = next_sample(data[3:0]);
      pair.end_flag = hdr_end;
      pair.loop_flag = hdr_loop;
      expected_pairs.push_back(pair);
      blk_pos = (blk_pos == BLOCK_LAST) ? 4'd0 : blk_pos + 4'd1;
    end
  endfunction

  function automatic void push_beat(input logic [7:0] data, input logic restart,
                                    input bit drain);
    stream_beat_t b;
    b.data_val = data;
    b.restart = restart;
    b.drain_first = drain;
    beat_queue.push_back(b);
  endfunction

  // driver
  always @(posedge clk) begin
    logic took;
    logic offer;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      took = in_tvalid && in_tready;
      if (took) begin
        decode_beat(in_tdata, in_tuser);
        void'(beat_queue.pop_front());
        if (burst_left > 0) burst_left--;
      end
      if (!in_tvalid || took) begin
        if (burst_left == 0 && gap_left == 0) begin
          burst_left = $urandom_range(1, 32);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        end
        offer = burst_left != 0 && beat_queue.size() != 0 &&
                !(beat_queue[0].drain_first && expected_pairs.size() != 0);
        if (burst_left == 0) gap_left--;
        in_tvalid <= offer;
        if (offer) begin
          in_tdata <= beat_queue[0].data_val;
          in_tuser <= beat_queue[0].restart;
        end
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (!hold_done && pairs_seen >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 80);
      end
      mode_left--;
      case (rx_mode)
        RX_OPEN: out_tready <= 1'b1;
        RX_COIN: out_tready <= 1'($urandom_range(0, 1));
        RX_LIGHT: out_tready <= ($urandom_range(0, 3) != 0);
        RX_HEAVY: out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= 1'b1;
      endcase
    end
  end

  // monitor
  always @(posedge clk) begin
    decoded_pair_t want;
    if (rst_n && out_tvalid && out_tready) begin
      pairs_seen++;
      if (expected_pairs.size() == 0) begin
        $error("result beat with nothing expected: tdata %h tuser %b", out_tdata, out_tuser);
        mismatches++;
      end else begin
        want = expected_pairs.pop_front();
        if (out_tdata[15:0] !== want.first) begin
          $error("sample_first: expected %0d, got %0d",
                 $signed(want.first), $signed(out_tdata[15:0]));
          mismatches++;
        end
        if (out_tdata[31:16] !== want.second) begin
          $error("sample_second: expected %0d, got %0d",
                 $signed(want.second), $signed(out_tdata[31:16]));
          mismatches++;
        end
        if (out_tuser[0] !== want.end_flag) begin
          $error("end_block: expected %0b, got %0b", want.end_flag, out_tuser[0]);
          mismatches++;
        end
        if (out_tuser[1] !== want.loop_flag) begin
          $error("loop_block: expected %0b, got %0b", want.loop_flag, out_tuser[1]);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[brr_block_decoder_top] ERROR");
        $finish;
      end
    end
  end

  initial begin
    int pick;
    bit resync;
    logic [7:0] v[$];

    // plain stream from reset, filter none, full block then wrap
    v = '{8'h00, 8'h7F, 8'h80, 8'hFF, 8'h00, 8'h88, 8'h77, 8'h0F, 8'hF0};
    foreach (v[i]) push_beat(v[i], 1'b0, 1'b0);
    // clamped shift, filter three, both flags; wait for drain first
    push_beat(8'hFF, 1'b0, 1'b1);
    v = '{8'h77, 8'h88, 8'h7F, 8'h80};
    foreach (v[i]) push_beat(v[i], 1'b0, 1'b0);
    // restart mid block: filter one, end flag
    push_beat(8'hD5, 1'b1, 1'b0);
    v = '{8'h77, 8'h77, 8'h88};
    foreach (v[i]) push_beat(v[i], 1'b0, 1'b0);
    // restart: filter two, loop flag
    push_beat(8'hEA, 1'b1, 1'b0);
    v = '{8'h77, 8'h88, 8'h81, 8'h18, 8'h7F};
    foreach (v[i]) push_beat(v[i], 1'b0, 1'b0);

    resync = 1'b1;
    while (beat_queue.size() < ITEM_TOTAL) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        push_beat(8'($urandom_range(0, 255)), 1'b1, 1'b0);
        repeat ($urandom_range(0, 7)) push_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        resync = 1'b1;
      end else if (pick == 1) begin
        repeat ($urandom_range(1, 5))
          push_beat(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0, 1'b0);
        resync = 1'b1;
      end else begin
        push_beat(8'($urandom_range(0, 255)), resync || ($urandom_range(0, 3) == 0),
                  $urandom_range(0, 19) == 0);
        repeat (8) push_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        resync = 1'b0;
      end
    end

    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    while (beat_queue.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_pairs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[brr_block_decoder_top] OK");
    end else begin
      $display("[brr_block_decoder_top] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/brr_pkg.sv
hdl/brr_pred.sv
hdl/brr_dp.sv
hdl/brr_ctrl.sv
hdl/brr_block_decoder_top.sv
test/tb_top.sv
